>>> hdl/u8ls_pkg.sv
`default_nettype none

package u8ls_pkg;

  localparam logic [7:0] ReplByte0 = 8'hEF;
  localparam logic [7:0] ReplByte1 = 8'hBF;
  localparam logic [7:0] ReplByte2 = 8'hBD;

  localparam logic [7:0] Lead2Lo = 8'hC2;
  localparam logic [7:0] Lead2Hi = 8'hDF;
  localparam logic [7:0] Lead3Lo = 8'hE0;
  localparam logic [7:0] Lead3Hi = 8'hEF;
  localparam logic [7:0] Lead4Lo = 8'hF0;
  localparam logic [7:0] Lead4Hi = 8'hF4;
  localparam logic [7:0] LeadSurr = 8'hED;
  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] Cont3Min = 8'hA0;
  localparam logic [7:0] Cont4Min = 8'h90;
  localparam logic [7:0] Cont4Max = 8'h8F;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= Lead2Lo && b <= Lead2Hi) len = 3'd2;
    if (b >= Lead3Lo && b <= Lead3Hi) len = 3'd3;
    if (b >= Lead4Lo && b <= Lead4Hi) len = 3'd4;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContTag;
  endfunction

  function automatic logic [7:0] repl_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = ReplByte0;
      2'd1:    b = ReplByte1;
      default: b = ReplByte2;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> hdl/utf8_lossy_sanitizer.sv
// Streaming UTF-8 cleaner.
// Input channel: in_byte_i/in_last_i with in_valid_i, held off by in_stall_o.
// Output channel: out_byte_o/out_last_o with out_valid_o, held off by out_stall_i.
// Well-formed UTF-8 passes unchanged; each bad lead byte, broken or out-of-range
// sequence gives one EF BF BD and only the lead byte is dropped. An incomplete
// sequence at in_last gives one replacement and the rest is dropped.
// Multi-byte sequences are held until complete, so an item may give no output.
// One item is taken at a time: in_stall_o stays high from the accept until the
// sequencer has decided every byte in its 4-byte window. The accept, each
// decision and each output byte are separate steps, and output bytes advance only
// while the receiver is not stalling. A worst-case item gives four replacements,
// twelve output bytes. After the accept, the scan state decides the window and the
// emit state loads the output register with the first output byte.
// out_last_o marks the final byte of a stream. A stall freezes the output
// register and the sequencer waits. Reset empties the window and the output
// register; nothing is held.
`default_nettype none

module utf8_lossy_sanitizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);
  import u8ls_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  localparam logic ModeCopy = 1'b0;
  localparam logic ModeRepl = 1'b1;

  logic [1:0] state_q, state_d;
  logic [2:0] n_q, n_d;
  logic [1:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic [2:0] e_q, e_d;
  logic       mode_q, mode_d;
  logic       drop_q, drop_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic [7:0] win_q [4];
  logic [7:0] win_d [4];

  logic [2:0] len;
  logic       ok;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign len = seq_len(win_q[0]);

  always_comb begin
    ok = is_cont(win_q[1]);
    if (len >= 3'd3 && !is_cont(win_q[2])) ok = 1'b0;
    if (len == 3'd4 && !is_cont(win_q[3])) ok = 1'b0;
    if (win_q[0] == Lead3Lo && win_q[1] < Cont3Min) ok = 1'b0;
    if (win_q[0] == LeadSurr && win_q[1] >= Cont3Min) ok = 1'b0;
    if (win_q[0] == Lead4Lo && win_q[1] < Cont4Min) ok = 1'b0;
    if (win_q[0] == Lead4Hi && win_q[1] > Cont4Max) ok = 1'b0;
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    e_d         = e_q;
    mode_d      = mode_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    win_d       = win_q;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          win_d[cnt_q] = in_byte_i;
          n_d          = {1'b0, cnt_q} + 3'd1;
          last_d       = in_last_i;
          state_d      = StScan;
        end
      end
      StScan: begin
        if (n_q == 3'd0) begin
          cnt_d   = 2'd0;
          state_d = StIdle;
        end else if (!win_q[0][7]) begin
          mode_d  = ModeCopy;
          e_d     = 3'd1;
          state_d = StEmit;
        end else if (len == 3'd0) begin
          mode_d  = ModeRepl;
          drop_d  = 1'b0;
          e_d     = 3'd0;
          state_d = StEmit;
        end else if (n_q < len) begin
          if (last_q) begin
            mode_d  = ModeRepl;
            drop_d  = 1'b1;
            e_d     = 3'd0;
            state_d = StEmit;
          end else begin
            cnt_d   = n_q[1:0];
            state_d = StIdle;
          end
        end else if (ok) begin
          mode_d  = ModeCopy;
          e_d     = len;
          state_d = StEmit;
        end else begin
          mode_d  = ModeRepl;
          drop_d  = 1'b0;
          e_d     = 3'd0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (mode_q == ModeCopy) begin
            out_byte_d = win_q[0];
            out_last_d = last_q && e_q == 3'd1 && n_q == 3'd1;
            win_d[0]   = win_q[1];
            win_d[1]   = win_q[2];
            win_d[2]   = win_q[3];
            n_d        = n_q - 3'd1;
            e_d        = e_q - 3'd1;
            if (e_q == 3'd1) state_d = StScan;
          end else begin
            out_byte_d = repl_byte(e_q[1:0]);
            out_last_d = 1'b0;
            if (e_q == 3'd2) begin
              out_last_d = last_q && (drop_q || n_q == 3'd1);
              if (drop_q) begin
                n_d = 3'd0;
              end else begin
                win_d[0] = win_q[1];
                win_d[1] = win_q[2];
                win_d[2] = win_q[3];
                n_d      = n_q - 3'd1;
              end
              state_d = StScan;
            end else begin
              e_d = e_q + 3'd1;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= 3'd0;
      cnt_q       <= 2'd0;
      last_q      <= 1'b0;
      e_q         <= 3'd0;
      mode_q      <= ModeCopy;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      e_q         <= e_d;
      mode_q      <= mode_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> n_q != 3'd0)
    else $error("emitting from an empty window");

  a_held_is_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && cnt_q != 2'd0) |-> seq_len(win_q[0]) > {1'b0, cnt_q})
    else $error("held bytes are not an unfinished sequence");

  a_copy_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && mode_q == ModeCopy) |-> (e_q != 3'd0 && e_q <= n_q))
    else $error("copy runs past the window");

  a_last_ends_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_free && out_valid_d && out_last_d) |=> (state_q == StScan && n_q == 3'd0))
    else $error("last marker before the window is spent");
`endif

endmodule

`default_nettype wire

>>> tb/utf8_lossy_sanitizer_test.sv
`timescale 1ns / 1ps

module utf8_lossy_sanitizer_test;
  import u8ls_pkg::*;

  localparam logic [7:0] ContMax = 8'hBF;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned RandomItems = 350;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } san_byte_t;

  class utf8_scoreboard;
    logic [7:0]  held[3];
    int unsigned held_n;
    san_byte_t   expect_q[$];
    int unsigned errors;
    int unsigned items;
    int unsigned results;
    int unsigned streams;
    int unsigned repls;

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function int unsigned lead_len(logic [7:0] b);
      if (b >= Lead2Lo && b <= Lead2Hi) return 2;
      if (b >= Lead3Lo && b <= Lead3Hi) return 3;
      if (b >= Lead4Lo && b <= Lead4Hi) return 4;
      return 0;
    endfunction

    function void emit(logic [7:0] b);
      san_byte_t e;
      e.b = b;
      e.last = 1'b0;
      expect_q = {expect_q, e};
    endfunction

    function void emit_repl();
      emit(ReplByte0);
      emit(ReplByte1);
      emit(ReplByte2);
      repls++;
    endfunction

    function int unsigned outstanding();
      return expect_q.size();
    endfunction

    // Accepted input item: work out the output bytes it releases.
    function void note_input(logic [7:0] b, logic last);
      logic [7:0]  win[4];
      int unsigned n, p, len, rem, i, first;
      bit          ok;
      first = expect_q.size();
      n = 0;
      p = 0;
      items++;
      for (i = 0; i < held_n; i++) win[n++] = held[i];
      win[n++] = b;
      held_n = 0;
      while (p < n) begin
        if (win[p] < ContTag) begin
          emit(win[p]);
          p++;
          continue;
        end
        len = lead_len(win[p]);
        if (len == 0) begin
          emit_repl();
          p++;
          continue;
        end
        rem = n - p;
        if (rem < len) begin
          if (last) begin
            emit_repl();
          end else begin
            for (i = 0; i < rem; i++) held[i] = win[p + i];
            held_n = rem;
          end
          break;
        end
        ok = 1'b1;
        for (i = 1; i < len; i++)
          if ((win[p + i] & ContMask) != ContTag) ok = 1'b0;
        if (ok) begin
          if (win[p] == Lead3Lo && win[p + 1] < Cont3Min) ok = 1'b0;
          if (win[p] == LeadSurr && win[p + 1] >= Cont3Min) ok = 1'b0;
          if (win[p] == Lead4Lo && win[p + 1] < Cont4Min) ok = 1'b0;
          if (win[p] == Lead4Hi && win[p + 1] > Cont4Max) ok = 1'b0;
        end
        if (!ok) begin
          emit_repl();
          p++;
          continue;
        end
        for (i = 0; i < len; i++) emit(win[p + i]);
        p += len;
      end
      if (last) begin
        streams++;
        if (expect_q.size() > first) expect_q[expect_q.size() - 1].last = 1'b1;
      end
    endfunction

    task check_result(logic [7:0] b, logic last);
      san_byte_t e;
      if (expect_q.size() == 0) begin
        report($sformatf("output byte %02h (last %0b) with nothing expected", b, last));
        return;
      end
      e = expect_q.pop_front();
      results++;
      if (b !== e.b)
        report($sformatf("output %0d: byte %02h, expected %02h", results, b, e.b));
      if (last !== e.last)
        report($sformatf("output %0d: last %0b, expected %0b", results, last, e.last));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  utf8_scoreboard sb = new();
  logic [7:0]     text_q[$];
  bit             quiet = 1'b0;
  int unsigned    sent = 0;
  int unsigned    idle_cycles = 0;

  utf8_lossy_sanitizer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Handshake monitor, receiver stalls and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_byte_i, in_last_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_byte_o, out_last_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("ERROR: no handshake for %0d cycles, %0d bytes outstanding",
                 idle_cycles, sb.outstanding());
        $display("Mismatches found");
        $finish;
      end
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 12);
    end
  end

  task send_item(logic [7:0] b, logic last);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task send_text();
    int unsigned i;
    for (i = 0; i < text_q.size(); i++) send_item(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  function void put_text(logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  function logic [7:0] cont_byte();
    return 8'($urandom_range(ContTag, ContMax));
  endfunction

  // Well-formed character of the given length.
  function void add_char(int unsigned len);
    logic [7:0] lead;
    int unsigned i;
    case (len)
      1: put_text(8'($urandom_range(0, ContTag - 1)));
      2: begin
        put_text(8'($urandom_range(Lead2Lo, Lead2Hi)));
        put_text(cont_byte());
      end
      3: begin
        lead = 8'($urandom_range(Lead3Lo, Lead3Hi));
        put_text(lead);
        if (lead == Lead3Lo) put_text(8'($urandom_range(Cont3Min, ContMax)));
        else if (lead == LeadSurr) put_text(8'($urandom_range(ContTag, Cont3Min - 1)));
        else put_text(cont_byte());
        put_text(cont_byte());
      end
      default: begin
        lead = 8'($urandom_range(Lead4Lo, Lead4Hi));
        put_text(lead);
        if (lead == Lead4Lo) put_text(8'($urandom_range(Cont4Min, ContMax)));
        else if (lead == Lead4Hi) put_text(8'($urandom_range(ContTag, Cont4Max)));
        else put_text(cont_byte());
        for (i = 2; i < 4; i++) put_text(cont_byte());
      end
    endcase
  endfunction

  // Multi-byte character with one flaw: a bad byte, a cut tail or a loose second byte.
  function void add_broken_char();
    int unsigned len, base, cut, i;
    len = $urandom_range(2, 4);
    base = text_q.size();
    add_char(len);
    case ($urandom_range(0, 2))
      0: text_q[base + $urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
      1: begin
        cut = $urandom_range(1, len - 1);
        for (i = 0; i < cut; i++) void'(text_q.pop_back());
      end
      default: text_q[base + 1] = cont_byte();
    endcase
  endfunction

  initial begin
    int unsigned s, units, u, r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ASCII ends, 2/3/4-byte edges, overlong, surrogate, above U+10FFFF,
    // bad leads, missing continuation, stream cut inside a sequence
    text_q = '{8'h41, 8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h9F, 8'h80,
               8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'hF0, 8'h90, 8'h80, 8'h80,
               8'hC0, 8'hFF, 8'hC2, 8'h41, 8'hE1, 8'h80};
    send_text();
    text_q = '{8'hF4};
    send_text();
    drain();

    s = 0;
    while (sent < RandomItems + 26) begin
      quiet = (s >= 6 && s < 11);
      if (s % 8 == 7) drain();
      units = $urandom_range(1, 8);
      for (u = 0; u < units; u++) begin
        r = $urandom_range(0, 99);
        if (r < 60) add_char($urandom_range(1, 4));
        else if (r < 80) add_broken_char();
        else put_text(8'($urandom_range(0, 255)));
      end
      send_text();
      s++;
    end
    quiet = 1'b0;

    drain();
    repeat (30) @(posedge clk_i);
    $display("Sent %0d bytes in %0d streams; checked %0d output bytes, %0d replacements",
             sb.items, sb.streams, sb.results, sb.repls);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
